[rtl/mms_pkg.sv]
// ----------------------------------------------------------------------------
// mms_pkg: shared types, codes and key functions
// Payload structs, register and encoding codes, and the order key used by the
// mode select cells.
// ----------------------------------------------------------------------------
package mms_pkg;

   localparam int VALUE_W = 64;
   localparam int CSR_W   = 6;

   // register indexes
   localparam logic CSR_VALUE_TYPE = 1'b0;
   localparam logic CSR_ARG_COUNT  = 1'b1;

   // value encodings; the fourth code behaves as float64
   localparam logic [1:0] VT_INT32   = 2'd0;
   localparam logic [1:0] VT_FLOAT32 = 2'd1;
   localparam logic [1:0] VT_FLOAT64 = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_null;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] mode_value;
      logic               mode_null;
   } rsp_type;

   // key carried along the compare lanes
   typedef struct packed {
      logic               v;
      logic [VALUE_W-1:0] key;
   } lane_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic count;
      logic select;
      logic rsp_load;
   } mms_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_COUNT,
      ST_SELECT,
      ST_DONE
   } mms_state_type;

   // Order-preserving unsigned key; float zero of either sign maps to +0.
   function automatic logic [VALUE_W-1:0] mms_key(input logic [VALUE_W-1:0] raw,
                                                  input logic [1:0] vt);
      logic [31:0]        c32;
      logic [VALUE_W-1:0] c64;
      logic [VALUE_W-1:0] k;
      c32 = raw[31:0];
      c64 = raw;
      case (vt)
         VT_INT32: begin
            k = {32'h0, c32 ^ 32'h8000_0000};
         end
         VT_FLOAT32: begin
            if (c32 == 32'h8000_0000) begin
               c32 = 32'h0;
            end
            k = c32[31] ? {32'h0, ~c32} : {32'h0, c32 | 32'h8000_0000};
         end
         default: begin
            if (c64 == 64'h8000_0000_0000_0000) begin
               c64 = '0;
            end
            k = c64[63] ? ~c64 : (c64 | 64'h8000_0000_0000_0000);
         end
      endcase
      return k;
   endfunction

   // Inverse of mms_key: canonical raw bits of a key.
   function automatic logic [VALUE_W-1:0] mms_value(input logic [VALUE_W-1:0] k,
                                                    input logic [1:0] vt);
      logic [VALUE_W-1:0] v;
      case (vt)
         VT_INT32: begin
            v = {32'h0, k[31:0] ^ 32'h8000_0000};
         end
         VT_FLOAT32: begin
            v = k[31] ? {32'h0, k[31:0] & 32'h7FFF_FFFF} : {32'h0, ~k[31:0]};
         end
         default: begin
            v = k[63] ? (k & 64'h7FFF_FFFF_FFFF_FFFF) : ~k;
         end
      endcase
      return v;
   endfunction

endpackage

[rtl/mms_cell.sv]
// ----------------------------------------------------------------------------
// mms_cell: one compare cell of the mode select chain
// Holds one value, counts matches seen on two passing key lanes, and merges
// its own count into the best-so-far token moving toward cell zero.
// ----------------------------------------------------------------------------
module mms_cell
   import mms_pkg::*;
#(
   parameter int CW = 6
) (
   input  logic               clock,
   input  mms_ctrl_type       ctrl,
   input  logic [1:0]         vt,
   input  logic               own_valid,
   input  logic [VALUE_W-1:0] val_in,
   input  lane_type           up_in,
   input  lane_type           dn_in,
   input  lane_type           dn_setup,
   input  logic [CW-1:0]      tok_cnt_in,
   input  logic [VALUE_W-1:0] tok_key_in,
   output logic [VALUE_W-1:0] val_out,
   output lane_type           own_out,
   output lane_type           up_out,
   output lane_type           dn_out,
   output logic [CW-1:0]      tok_cnt_out,
   output logic [VALUE_W-1:0] tok_key_out
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] key_own;
   lane_type           up_ff;
   lane_type           dn_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      cnt_in;
   logic [CW-1:0]      tok_cnt_ff;
   logic [VALUE_W-1:0] tok_key_ff;
   logic               up_hit;
   logic               dn_hit;
   logic               take_own;

   assign key_own = mms_key(value_ff, vt);
   assign up_hit  = own_valid && up_ff.v && (up_ff.key == key_own);
   assign dn_hit  = own_valid && dn_ff.v && (dn_ff.key == key_own);
   assign cnt_in  = cnt_ff + CW'(up_hit) + CW'(dn_hit);

   // higher count wins, larger key on a tie
   assign take_own = own_valid && ((cnt_ff > tok_cnt_in) ||
                     ((cnt_ff == tok_cnt_in) && (key_own > tok_key_in)));

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= val_in;
      end
      if (ctrl.setup) begin
         up_ff  <= '{v: own_valid, key: key_own};
         dn_ff  <= dn_setup;
         cnt_ff <= '0;
      end else if (ctrl.count) begin
         up_ff  <= up_in;
         dn_ff  <= dn_in;
         cnt_ff <= cnt_in;
      end
      // clear the token at setup, hold it after the select pass
      if (ctrl.select) begin
         tok_cnt_ff <= take_own ? cnt_ff : tok_cnt_in;
         tok_key_ff <= take_own ? key_own : tok_key_in;
      end else if (ctrl.setup) begin
         tok_cnt_ff <= '0;
         tok_key_ff <= '0;
      end
   end

   assign val_out     = value_ff;
   assign own_out     = '{v: own_valid, key: key_own};
   assign up_out      = up_ff;
   assign dn_out      = dn_ff;
   assign tok_cnt_out = tok_cnt_ff;
   assign tok_key_out = tok_key_ff;

endmodule

[rtl/mms_ctrl.sv]
// ----------------------------------------------------------------------------
// mms_ctrl: sequencer of the mode select chain
// Counts loaded values, runs the setup, count and select passes, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module mms_ctrl
   import mms_pkg::*;
#(
   parameter int MAX_ARGS = 32,
   parameter int CW       = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_is_null,
   input  logic               rsp_stall,
   input  logic [CSR_W-1:0]   arg_count,
   output mms_ctrl_type       ctrl,
   output logic [CW-1:0]      fill,
   output logic               null_seen,
   output logic               req_stall,
   output logic               rsp_valid
);

   localparam int AW = (CW > CSR_W) ? CW : CSR_W;

   mms_state_type state_ff, state_in;
   logic [CW-1:0] item_ff, item_in;
   logic [CW-1:0] step_ff, step_in;
   logic          null_ff, null_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] argc_w;
   logic [CW-1:0] lim;
   logic [CW-1:0] item_next;
   logic          last_step;

   // clamp the cell size to 1..MAX_ARGS
   always_comb begin
      argc_w = AW'(arg_count);
      if (argc_w == '0) begin
         lim = CW'(1);
      end else if (argc_w > AW'(MAX_ARGS)) begin
         lim = CW'(MAX_ARGS);
      end else begin
         lim = CW'(argc_w);
      end
   end

   assign item_next = item_ff + CW'(1);
   assign last_step = (step_ff == (item_ff - CW'(1)));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      null_in      = null_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               item_in   = item_next;
               null_in   = null_ff | req_is_null;
               if (item_next >= lim) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            ctrl.setup = 1'b1;
            step_in    = '0;
            state_in   = ST_COUNT;
         end
         ST_COUNT: begin
            ctrl.count = 1'b1;
            step_in    = step_ff + CW'(1);
            if (last_step) begin
               step_in  = '0;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            ctrl.select = 1'b1;
            step_in     = step_ff + CW'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               item_in       = '0;
               null_in       = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         item_ff      <= '0;
         step_ff      <= '0;
         null_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_ff      <= item_in;
         step_ff      <= step_in;
         null_ff      <= null_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign fill      = item_ff;
   assign null_seen = null_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/multiset_mode_select_unit.sv]
// ----------------------------------------------------------------------------
// multiset_mode_select_unit: mode of a cell of values
// A cell of n values (n = arg_count, 1..MAX_ARGS) takes n transactions, then
// a setup step, a count pass and a select pass through the cell chain.
// Requests stall during the chain passes, so a new cell loads only after the
// last one is through; the result register lets the next cell load while it waits.
// Reset clears the sequencer, result valid and the configuration registers; values are not.
// ----------------------------------------------------------------------------
module multiset_mode_select_unit
   import mms_pkg::*;
#(
   parameter int MAX_ARGS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_ARGS + 1);

   logic [1:0]         vt_ff;
   logic [CSR_W-1:0]   argc_ff;
   mms_ctrl_type       ctrl;
   logic [CW-1:0]      fill;
   logic               null_seen;
   rsp_type            rsp_ff;

   logic [VALUE_W-1:0] val    [MAX_ARGS];
   lane_type           own    [MAX_ARGS];
   lane_type           up     [MAX_ARGS];
   lane_type           dn     [MAX_ARGS];
   logic [CW-1:0]      tok_cnt[MAX_ARGS];
   logic [VALUE_W-1:0] tok_key[MAX_ARGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff   <= VT_INT32;
         argc_ff <= CSR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_VALUE_TYPE: vt_ff   <= csr_wdata[1:0];
            CSR_ARG_COUNT:  argc_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mms_ctrl #(
      .MAX_ARGS (MAX_ARGS),
      .CW       (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_null (req_data.is_null),
      .rsp_stall   (rsp_stall),
      .arg_count   (argc_ff),
      .ctrl        (ctrl),
      .fill        (fill),
      .null_seen   (null_seen),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid)
   );

   // values shift in at cell 0; up lane runs toward the top, down lane and
   // token toward cell 0
   for (genvar j = 0; j < MAX_ARGS; j++) begin : g_cell
      logic [VALUE_W-1:0] val_in;
      lane_type           up_in;
      lane_type           dn_in;
      lane_type           dn_setup;
      logic [CW-1:0]      tok_cnt_in;
      logic [VALUE_W-1:0] tok_key_in;
      logic               own_valid;

      assign own_valid = (CW'(j) < fill);

      if (j == 0) begin : g_first
         assign val_in = req_data.value;
         assign up_in  = '0;
      end else begin : g_mid
         assign val_in = val[j-1];
         assign up_in  = up[j-1];
      end

      if (j == MAX_ARGS - 1) begin : g_last
         assign dn_in      = '0;
         assign dn_setup   = '0;
         assign tok_cnt_in = '0;
         assign tok_key_in = '0;
      end else begin : g_inner
         assign dn_in      = dn[j+1];
         assign dn_setup   = own[j+1];
         assign tok_cnt_in = tok_cnt[j+1];
         assign tok_key_in = tok_key[j+1];
      end

      mms_cell #(
         .CW (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .vt          (vt_ff),
         .own_valid   (own_valid),
         .val_in      (val_in),
         .up_in       (up_in),
         .dn_in       (dn_in),
         .dn_setup    (dn_setup),
         .tok_cnt_in  (tok_cnt_in),
         .tok_key_in  (tok_key_in),
         .val_out     (val[j]),
         .own_out     (own[j]),
         .up_out      (up[j]),
         .dn_out      (dn[j]),
         .tok_cnt_out (tok_cnt[j]),
         .tok_key_out (tok_key[j])
      );
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_ff.mode_null  <= null_seen;
         rsp_ff.mode_value <= null_seen ? '0 : mms_value(tok_key[0], vt_ff);
      end
   end

   assign rsp_data = rsp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while held");

   a_setup_then_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.setup |=> (ctrl.count && req_stall))
      else $error("count pass did not follow setup");

   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mode_null) |-> (rsp_data.mode_value == '0))
      else $error("null result carries a value");

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.setup, ctrl.count, ctrl.select, ctrl.rsp_load}))
      else $error("more than one chain phase active");

endmodule

[verif/multiset_mode_select_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_mode_select_unit_test: self-checking bench for the mode select unit
// Feeds cells of raw values under all value encodings and random cell sizes, keeps
// its own model of the most frequent value per cell and compares every result
// transaction in order. Requests idle and results stall at random.
// ----------------------------------------------------------------------------
module multiset_mode_select_unit_test;
   import mms_pkg::*;

   localparam int ARGS_MAX      = 32;
   localparam int ITEM_TARGET   = 1750;
   localparam int SETTLE_CYCLES = 3 * ARGS_MAX + 16;
   localparam int HOLD_CYCLES   = 600;
   // fourth encoding code, handled as float64 by the unit
   localparam logic [1:0] VT_RESERVED = 2'd3;

   class mode_scoreboard;
      logic [1:0]  vt_reg  = VT_INT32;
      logic [5:0]  cnt_reg = 6'd1;
      logic [63:0] cell_vals [ARGS_MAX];
      int          loaded    = 0;
      bit          null_flag = 1'b0;
      rsp_type     expected [$];
      int          errors    = 0;

      function void set_reg(logic idx, logic [5:0] v);
         if (idx == CSR_VALUE_TYPE) begin
            vt_reg = v[1:0];
         end else begin
            cnt_reg = v;
         end
      endfunction

      // fold a float zero of either sign into +0, keep 32-bit types in 32 bits
      function logic [63:0] norm(logic [63:0] raw, logic [1:0] enc);
         case (enc)
            VT_INT32: begin
               return {32'h0, raw[31:0]};
            end
            VT_FLOAT32: begin
               return (raw[31:0] == 32'h8000_0000) ? 64'h0 : {32'h0, raw[31:0]};
            end
            default: begin
               return (raw == 64'h8000_0000_0000_0000) ? 64'h0 : raw;
            end
         endcase
      endfunction

      // unsigned key whose order matches the numeric order of the encoding
      function logic [63:0] rank(logic [63:0] c, logic [1:0] enc);
         case (enc)
            VT_INT32: begin
               return {32'h0, c[31:0] ^ 32'h8000_0000};
            end
            VT_FLOAT32: begin
               return c[31] ? {32'h0, ~c[31:0]} : {32'h0, c[31:0] | 32'h8000_0000};
            end
            default: begin
               return c[63] ? ~c : (c | 64'h8000_0000_0000_0000);
            end
         endcase
      endfunction

      function void note_input(req_type t);
         int          lim;
         int          n;
         int          hits;
         int          best_hits;
         logic [1:0]  enc;
         logic [63:0] ki;
         logic [63:0] best_key;
         logic [63:0] best_val;
         rsp_type     e;
         lim = int'(cnt_reg);
         if (lim < 1) lim = 1;
         if (lim > ARGS_MAX) lim = ARGS_MAX;
         if (loaded < ARGS_MAX) cell_vals[loaded] = t.value;
         null_flag |= t.is_null;
         loaded++;
         if (loaded < lim) return;
         enc = (vt_reg == VT_INT32 || vt_reg == VT_FLOAT32) ? vt_reg : VT_FLOAT64;
         n = (loaded > ARGS_MAX) ? ARGS_MAX : loaded;
         best_hits = 0;
         best_key  = '0;
         best_val  = '0;
         for (int i = 0; i < n; i++) begin
            ki   = rank(norm(cell_vals[i], enc), enc);
            hits = 0;
            for (int j = 0; j < n; j++) begin
               if (rank(norm(cell_vals[j], enc), enc) == ki) hits++;
            end
            if (hits > best_hits || (hits == best_hits && ki > best_key)) begin
               best_hits = hits;
               best_key  = ki;
               best_val  = norm(cell_vals[i], enc);
            end
         end
         e.mode_null  = null_flag;
         e.mode_value = null_flag ? 64'h0 : best_val;
         expected.push_back(e);
         loaded    = 0;
         null_flag = 1'b0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            report($sformatf("result %h null %b with no cell pending",
                             got.mode_value, got.mode_null));
            return;
         end
         want = expected.pop_front();
         if (got.mode_value !== want.mode_value) begin
            report($sformatf("mode_value %h, want %h", got.mode_value, want.mode_value));
         end
         if (got.mode_null !== want.mode_null) begin
            report($sformatf("mode_null %b, want %b", got.mode_null, want.mode_null));
         end
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_index = CSR_VALUE_TYPE;
   logic [CSR_W-1:0] csr_wdata = '0;

   mode_scoreboard sb = new();
   int unsigned burst_left = 0;
   int unsigned sent = 0;
   bit          hold_go = 1'b0;

   multiset_mode_select_unit #(
      .MAX_ARGS (ARGS_MAX)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic write_reg(logic idx, logic [CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // offer one transaction, with bursts and random gaps between them
   task automatic offer(req_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(t);
      sent++;
   endtask

   task automatic push_value(logic [63:0] v, logic nul);
      req_type t;
      t.value   = v;
      t.is_null = nul;
      offer(t);
   endtask

   // drop valid, wait for every pending result, then let the chain go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] fresh_value(logic [1:0] vt);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) begin
         case (vt)
            VT_INT32: begin
               case ($urandom_range(0, 5))
                  0: raw = 64'h0;
                  1: raw = 64'h1;
                  2: raw = 64'hFFFF_FFFF;
                  3: raw = 64'h7FFF_FFFF;
                  4: raw = 64'h8000_0000;
                  default: raw = 64'h8000_0001;
               endcase
            end
            VT_FLOAT32: begin
               case ($urandom_range(0, 8))
                  0: raw = 64'h0;
                  1: raw = 64'h3F80_0000;
                  2: raw = 64'hBF80_0000;
                  3: raw = 64'h7F80_0000;
                  4: raw = 64'hFF80_0000;
                  5: raw = 64'h7FC0_0000;
                  6: raw = 64'hFFC0_0000;
                  7: raw = 64'h0000_0001;
                  default: raw = 64'h807F_FFFF;
               endcase
            end
            default: begin
               case ($urandom_range(0, 8))
                  0: raw = 64'h0;
                  1: raw = 64'h3FF0_0000_0000_0000;
                  2: raw = 64'hBFF0_0000_0000_0000;
                  3: raw = 64'h7FF0_0000_0000_0000;
                  4: raw = 64'hFFF0_0000_0000_0000;
                  5: raw = 64'h7FF8_0000_0000_0000;
                  6: raw = 64'hFFF8_0000_0000_0000;
                  7: raw = 64'h0000_0000_0000_0001;
                  default: raw = 64'hFFFF_FFFF_FFFF_FFFF;
               endcase
            end
         endcase
      end
      return raw;
   endfunction

   // one cell of n values, mostly drawn from a small pool so that repeats and ties occur
   task automatic run_cell(logic [1:0] vt, int n);
      logic [63:0] pool [4];
      logic [63:0] v;
      int          kinds;
      bit          distinct;
      bit          nulls;
      for (int i = 0; i < 4; i++) pool[i] = fresh_value(vt);
      kinds    = $urandom_range(1, (n < 4) ? n : 4);
      distinct = ($urandom_range(0, 7) == 0);
      nulls    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         v = distinct ? fresh_value(vt) : pool[$urandom_range(0, kinds - 1)];
         if (vt == VT_INT32 || vt == VT_FLOAT32) begin
            v[63:32] = $urandom;
            if (vt == VT_FLOAT32 && v[30:0] == 31'h0) v[31] = 1'($urandom_range(0, 1));
         end else if (v[62:0] == 63'h0) begin
            v[63] = 1'($urandom_range(0, 1));
         end
         push_value(v, nulls && ($urandom_range(0, 3) == 0));
      end
   endtask

   initial begin : rsp_side
      int seg_left;
      int stall_pct;
      int hold_left;
      seg_left  = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(10, 150);
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  default: stall_pct = 70;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [1:0]       vt;
      logic [CSR_W-1:0] ac;
      int               eff;
      int               cells;
      int               phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: int32, one value per cell
      push_value({32'hDEAD_BEEF, 32'h7FFF_FFFF}, 1'b0);
      push_value({32'hFFFF_FFFF, 32'h8000_0000}, 1'b0);
      push_value(64'h0, 1'b1);
      settle();

      // float32: signed zeros collapse, NaNs rank outside the infinities
      write_reg(CSR_VALUE_TYPE, {4'b1010, VT_FLOAT32});
      write_reg(CSR_ARG_COUNT, 6'd4);
      push_value(64'h8000_0000, 1'b0);
      push_value(64'h0, 1'b0);
      push_value(64'h3F80_0000, 1'b0);
      push_value(64'hFF80_0000, 1'b0);
      push_value(64'h7FC0_0000, 1'b0);
      push_value(64'h7F80_0000, 1'b0);
      push_value(64'hFFC0_0000, 1'b0);
      push_value(64'hFFC0_0000, 1'b0);
      settle();

      // reserved encoding and a zero cell size
      write_reg(CSR_VALUE_TYPE, {4'b0000, VT_RESERVED});
      write_reg(CSR_ARG_COUNT, 6'd0);
      push_value(64'h8000_0000_0000_0000, 1'b0);
      push_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      settle();

      // float64 tie goes to the larger value; a null poisons its cell
      write_reg(CSR_VALUE_TYPE, {4'b0000, VT_FLOAT64});
      write_reg(CSR_ARG_COUNT, 6'd2);
      push_value(64'h7FF0_0000_0000_0000, 1'b0);
      push_value(64'hFFF8_0000_0000_0000, 1'b0);
      push_value(64'h3FF0_0000_0000_0000, 1'b1);
      push_value(64'h3FF0_0000_0000_0000, 1'b0);
      settle();

      // shrink the cell size while a cell is partly loaded
      write_reg(CSR_VALUE_TYPE, {4'b0000, VT_INT32});
      write_reg(CSR_ARG_COUNT, 6'd5);
      push_value(64'h7, 1'b0);
      push_value(64'hFFFF_FFFF, 1'b0);
      push_value(64'hFFFF_FFFF, 1'b0);
      settle();
      write_reg(CSR_ARG_COUNT, 6'd2);
      push_value(64'h7, 1'b0);

      phase = 0;
      while (sent < ITEM_TARGET) begin
         settle();
         vt = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 19))
            0: ac = 6'd0;
            1: ac = 6'd32;
            2: ac = 6'($urandom_range(33, 63));
            3, 4, 5: ac = 6'($urandom_range(9, 31));
            default: ac = 6'($urandom_range(1, 8));
         endcase
         if (phase == 0) ac = 6'd1;
         write_reg(CSR_VALUE_TYPE, {4'($urandom), vt});
         write_reg(CSR_ARG_COUNT, ac);
         eff   = (ac == 0) ? 1 : ((int'(ac) > ARGS_MAX) ? ARGS_MAX : int'(ac));
         cells = (eff >= 16) ? $urandom_range(1, 3) : $urandom_range(4, 30);
         if (phase == 0) begin
            // long receiver hold-off while single-value cells keep coming
            cells   = 80;
            hold_go = 1'b1;
         end
         repeat (cells) run_cell(vt, eff);
         phase++;
      end
      settle();

      if (sb.errors == 0) begin
         $display("multiset_mode_select_unit_test: PASS");
      end else begin
         $display("multiset_mode_select_unit_test: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("multiset_mode_select_unit_test: FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/mms_pkg.sv
rtl/mms_cell.sv
rtl/mms_ctrl.sv
rtl/multiset_mode_select_unit.sv
verif/multiset_mode_select_unit_test.sv
